[rtl/ils_pkg.sv]
// Shared types and codes for the indexed list store.
package ils_pkg;

    typedef enum logic [2:0] {
        CMD_GET    = 3'd0,
        CMD_SET    = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_FIND   = 3'd4,
        CMD_APPEND = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_RANGE   = 2'd1,
        STS_FULL    = 2'd2,
        STS_MISSING = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        COP_HOLD,
        COP_SET,
        COP_INSERT,
        COP_DELETE,
        COP_ROTATE
    } t_cell_op;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    localparam int unsigned VALUE_BITS = 32;
    localparam int unsigned INDEX_BITS = 8;
    localparam int unsigned FOUND_BITS = 6;
    localparam int unsigned COUNT_BITS = 7;

endpackage

[rtl/ils_cmd_if.sv]
// Command channel carrying one list operation per word.
interface ils_cmd_if;
    logic              valid;
    logic              ready;
    logic [2:0]        command;
    logic signed [7:0] index;
    logic [31:0]       value;

    modport source (output valid, command, index, value, input ready);
    modport sink (input valid, command, index, value, output ready);
endinterface

[rtl/ils_rsp_if.sv]
// Response channel carrying one result word per command.
interface ils_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [5:0]  found_index;
    logic [6:0]  count_after;

    modport source (output valid, status, read_value, found_index, count_after, input ready);
    modport sink (input valid, status, read_value, found_index, count_after, output ready);
endinterface

[rtl/indexed_list_store_top.sv]
// Top level of the indexed list store: a chain of entry cells and its controller.
//
//   Channel  Direction  Payload
//   i_cmd    in         command[2:0], index[7:0] signed, value[31:0]
//   o_rsp    out        status[1:0], read_value[31:0], found_index[5:0], count_after[6:0]
//
// Set, insert, delete, append, unused commands, range errors and find on an empty list
// finish without a scan, since every cell shifts or loads in parallel.
// Get and find rotate the occupied cells past cell zero, one step a cycle, once through
// every entry in the list.
// Reset empties the list at once; no clearing pass runs.
// A held response blocks new commands, and commands are not taken during a rotation.
module indexed_list_store_top
    import ils_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ils_cmd_if.sink     i_cmd,
    ils_rsp_if.source   o_rsp
);
    localparam int AW = $clog2(DEPTH);

    t_cell_op             cell_op;
    logic [AW-1:0]        cell_pos;
    logic [AW-1:0]        cell_last;
    logic [WORD_BITS-1:0] cell_word;
    logic [WORD_BITS-1:0] cell_data [DEPTH];

    ils_ctrl #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_rsp   (o_rsp),
        .i_head  (cell_data[0]),
        .o_op    (cell_op),
        .o_pos   (cell_pos),
        .o_last  (cell_last),
        .o_word  (cell_word)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_BITS-1:0] left_data;
        logic [WORD_BITS-1:0] right_data;

        if (g == 0) begin : g_first
            assign left_data = '0;
        end else begin : g_inner_left
            assign left_data = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_data = '0;
        end else begin : g_inner_right
            assign right_data = cell_data[g+1];
        end

        ils_cell #(
            .DEPTH     (DEPTH),
            .WORD_BITS (WORD_BITS),
            .IDX       (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op),
            .i_pos   (cell_pos),
            .i_last  (cell_last),
            .i_word  (cell_word),
            .i_left  (left_data),
            .i_right (right_data),
            .i_head  (cell_data[0]),
            .o_data  (cell_data[g])
        );
    end
endmodule

[rtl/ils_cell.sv]
// One storage cell of the list chain; it holds a single entry.
module ils_cell
    import ils_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32,
    parameter int IDX       = 0
) (
    input  logic                         i_clk,
    input  t_cell_op                     i_op,
    input  logic [$clog2(DEPTH)-1:0]     i_pos,
    input  logic [$clog2(DEPTH)-1:0]     i_last,
    input  logic [WORD_BITS-1:0]         i_word,
    input  logic [WORD_BITS-1:0]         i_left,
    input  logic [WORD_BITS-1:0]         i_right,
    input  logic [WORD_BITS-1:0]         i_head,
    output logic [WORD_BITS-1:0]         o_data
);
    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] MY_POS = AW'(IDX);

    logic [WORD_BITS-1:0] r_data;
    logic [WORD_BITS-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_op)
            COP_SET: begin
                if (MY_POS == i_pos) begin
                    n_data = i_word;
                end
            end
            COP_INSERT: begin
                if (MY_POS == i_pos) begin
                    n_data = i_word;
                end else if (MY_POS > i_pos) begin
                    n_data = i_left;
                end
            end
            COP_DELETE: begin
                if (MY_POS >= i_pos) begin
                    n_data = i_right;
                end
            end
            COP_ROTATE: begin
                if (MY_POS == i_last) begin
                    n_data = i_head;
                end else if (MY_POS < i_last) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
endmodule

[rtl/ils_ctrl.sv]
// Command decode, scan sequencer and response register of the list store.
module ils_ctrl
    import ils_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    ils_cmd_if.sink                   i_cmd,
    ils_rsp_if.source                 o_rsp,
    input  logic [WORD_BITS-1:0]      i_head,
    output t_cell_op                  o_op,
    output logic [$clog2(DEPTH)-1:0]  o_pos,
    output logic [$clog2(DEPTH)-1:0]  o_last,
    output logic [WORD_BITS-1:0]      o_word
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = ((CW > INDEX_BITS) ? CW : INDEX_BITS) + 2;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    t_state               r_state;
    t_state               n_state;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_find;
    logic [AW-1:0]        r_pos;
    logic [WORD_BITS-1:0] r_word;
    logic [AW-1:0]        r_step;
    logic                 r_hit;
    logic [AW-1:0]        r_fidx;
    logic [WORD_BITS-1:0] r_rdata;
    logic                 r_rsp_valid;
    t_status              r_status;
    logic [31:0]          r_rd;
    logic [FOUND_BITS-1:0] r_fi;

    logic                 accept;
    logic [PW-1:0]        idx_ext;
    logic [PW-1:0]        count_ext;
    logic [PW-1:0]        pos_s;
    logic                 in_list;
    logic                 ins_ok;
    logic                 full;
    logic [WORD_BITS-1:0] word_in;
    logic [AW-1:0]        last_pos;
    logic                 start_scan;
    logic                 done_now;
    t_status              done_status;
    logic                 scan_last;
    logic                 hit_now;
    logic                 fin_hit;
    logic [AW-1:0]        fin_idx;
    logic [WORD_BITS-1:0] fin_data;

    assign i_cmd.ready = (r_state == ST_IDLE) && (!r_rsp_valid || o_rsp.ready);
    assign accept      = i_cmd.valid && i_cmd.ready;

    assign idx_ext   = {{(PW - INDEX_BITS){i_cmd.index[INDEX_BITS-1]}}, i_cmd.index};
    assign count_ext = PW'(r_count);
    assign pos_s     = idx_ext + (i_cmd.index[INDEX_BITS-1] ? count_ext : '0);
    assign in_list   = !pos_s[PW-1] && (pos_s < count_ext);
    assign ins_ok    = !pos_s[PW-1] && (pos_s <= count_ext);
    assign full      = (r_count == FULL_COUNT);
    assign word_in   = WORD_BITS'(i_cmd.value);
    assign last_pos  = AW'(r_count - 1'b1);

    assign scan_last = (r_step == last_pos);
    assign hit_now   = r_find && !r_hit && (i_head == r_word);
    assign fin_hit   = r_hit || hit_now;
    assign fin_idx   = r_hit ? r_fidx : r_step;
    assign fin_data  = (r_step == r_pos) ? i_head : r_rdata;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start_scan) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_op        = COP_HOLD;
        o_pos       = AW'(pos_s);
        o_last      = last_pos;
        o_word      = word_in;
        start_scan  = 1'b0;
        done_now    = 1'b0;
        done_status = STS_OK;
        n_count     = r_count;
        if (r_state == ST_SCAN) begin
            o_op = COP_ROTATE;
        end else if (accept) begin
            unique case (t_cmd'(i_cmd.command))
                CMD_GET: begin
                    if (in_list) begin
                        start_scan = 1'b1;
                    end else begin
                        done_now    = 1'b1;
                        done_status = STS_RANGE;
                    end
                end
                CMD_SET: begin
                    done_now = 1'b1;
                    if (in_list) begin
                        o_op = COP_SET;
                    end else begin
                        done_status = STS_RANGE;
                    end
                end
                CMD_INSERT: begin
                    done_now = 1'b1;
                    if (!ins_ok) begin
                        done_status = STS_RANGE;
                    end else if (full) begin
                        done_status = STS_FULL;
                    end else begin
                        o_op    = COP_INSERT;
                        n_count = r_count + 1'b1;
                    end
                end
                CMD_DELETE: begin
                    done_now = 1'b1;
                    if (in_list) begin
                        o_op    = COP_DELETE;
                        n_count = r_count - 1'b1;
                    end else begin
                        done_status = STS_RANGE;
                    end
                end
                CMD_FIND: begin
                    if (r_count == '0) begin
                        done_now    = 1'b1;
                        done_status = STS_MISSING;
                    end else begin
                        start_scan = 1'b1;
                    end
                end
                CMD_APPEND: begin
                    done_now = 1'b1;
                    o_pos    = AW'(r_count);
                    if (full) begin
                        done_status = STS_FULL;
                    end else begin
                        o_op    = COP_INSERT;
                        n_count = r_count + 1'b1;
                    end
                end
                default: begin
                    done_now = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (done_now || (r_state == ST_SCAN && scan_last)) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_scan) begin
            r_find <= (t_cmd'(i_cmd.command) == CMD_FIND);
            r_pos  <= AW'(pos_s);
            r_word <= word_in;
            r_step <= '0;
            r_hit  <= 1'b0;
        end else if (r_state == ST_SCAN) begin
            r_step  <= r_step + 1'b1;
            r_rdata <= fin_data;
            if (hit_now) begin
                r_hit  <= 1'b1;
                r_fidx <= r_step;
            end
        end
        if (done_now) begin
            r_status <= done_status;
            r_rd     <= '0;
            r_fi     <= '0;
        end else if (r_state == ST_SCAN && scan_last) begin
            if (r_find) begin
                r_status <= fin_hit ? STS_OK : STS_MISSING;
                r_rd     <= '0;
                r_fi     <= fin_hit ? FOUND_BITS'(fin_idx) : '0;
            end else begin
                r_status <= STS_OK;
                r_rd     <= 32'(fin_data);
                r_fi     <= '0;
            end
        end
    end

    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.read_value  = r_rd;
    assign o_rsp.found_index = r_fi;
    assign o_rsp.count_after = COUNT_BITS'(r_count);

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("Entry count exceeds capacity.");

    a_scan_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !i_cmd.ready)
        else $error("Command accepted during a scan.");

    a_scan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && scan_last) |=> (r_rsp_valid && r_state == ST_IDLE))
        else $error("Scan ended without a result.");

    a_delete_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && t_cmd'(i_cmd.command) == CMD_DELETE && in_list)
        |=> (r_count == CW'($past(r_count) - 1'b1)))
        else $error("Delete did not shrink the list.");
`endif
endmodule
